FILE: hw/rtl/pab_pkg.sv
// ----------------------------------------------------------------------------
// pab_pkg - shared types and constants for the ADPCM block decoder
// Payload structs, controller/datapath link types and predictor tables.
// ----------------------------------------------------------------------------
package pab_pkg;

	localparam int MAX_BLOCKS = 65536;
	localparam logic [15:0] BLOCK_LIMIT =
		(MAX_BLOCKS > 65536) ? 16'hFFFF : 16'(MAX_BLOCKS - 1);

	localparam int SAMPLES_PER_BLOCK = 28;
	localparam int IDX_W = 5;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_BLOCK - 1);

	localparam int HIST_W = 40;   // Q23.16
	localparam int ACC_W  = 48;
	localparam int COEF_W = 7;

	typedef struct packed {
		logic        start_of_sample;
		logic [3:0]  shift_range;
		logic [3:0]  filter_select;
		logic        flag_end;
		logic        flag_repeat;
		logic        flag_loop_start;
		logic [55:0] data_low;
		logic [55:0] data_high;
		logic        final_block;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [4:0]         sample_index;
		logic [15:0]        block_index;
		logic               loop_start_here;
		logic               loop_repeat;
		logic               last;
		logic               sample_done;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic             load;
		logic             step;
		logic [IDX_W-1:0] idx;
	} pab_cmd_t;

	typedef struct packed {
		logic slot_free;
	} pab_status_t;

	// Predictor coefficients in 64ths; unknown filters behave as filter 0.
	function automatic logic [COEF_W-1:0] coef_one(input logic [3:0] filt);
		logic [COEF_W-1:0] c;
		unique case (filt)
			4'd1:    c = 7'd60;
			4'd2:    c = 7'd115;
			4'd3:    c = 7'd98;
			4'd4:    c = 7'd122;
			default: c = 7'd0;
		endcase
		return c;
	endfunction

	function automatic logic [COEF_W-1:0] coef_two(input logic [3:0] filt);
		logic [COEF_W-1:0] c;
		unique case (filt)
			4'd2:    c = 7'd52;
			4'd3:    c = 7'd55;
			4'd4:    c = 7'd60;
			default: c = 7'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/pab_ctrl.sv
// ----------------------------------------------------------------------------
// pab_ctrl - block sequencer
// Accepts a block, then steps the datapath once per sample slot that the
// output register can take, 28 steps per block.
// ----------------------------------------------------------------------------
module pab_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output pab_pkg::pab_cmd_t    cmd,
	input  pab_pkg::pab_status_t status
);
	import pab_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             last_step;

	assign last_step = (state_q == ST_RUN) && status.slot_free && (idx_q == LAST_IDX);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (last_step) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		cmd.idx  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.step = status.slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			// restart the sample count per block, advance on each step
			if (cmd.load) idx_q <= '0;
			else if (cmd.step) idx_q <= idx_q + IDX_W'(1);
		end
	end

	a_step_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> state_q == ST_RUN)
		else $error("step issued outside RUN");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_RUN && idx_q == '0))
		else $error("load did not start a block at sample 0");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && idx_q == LAST_IDX) |=> state_q == ST_IDLE)
		else $error("block did not end after the last sample");

endmodule

FILE: hw/rtl/pab_datapath.sv
// ----------------------------------------------------------------------------
// pab_datapath - nibble expansion, two-tap predictor and output register
// Holds the block payload, the predictor history and the block counter.
// ----------------------------------------------------------------------------
module pab_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pab_pkg::in_item_t     in_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_data,
	input  pab_pkg::pab_cmd_t     cmd,
	output pab_pkg::pab_status_t  status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pab_pkg::out_item_t    out_data
);
	import pab_pkg::*;

	// control state
	logic                     marks_en_q;
	logic signed [HIST_W-1:0] h1_q, h2_q;
	logic [15:0]              block_cnt_q;
	logic                     out_valid_q;

	// payload held for the block in progress
	logic [111:0]      nib_q;
	logic [3:0]        range_q;
	logic [COEF_W-1:0] c1_q, c2_q;
	logic              mark_start_q, mark_rep_q, final_q;
	logic [15:0]       bidx_q;
	out_item_t         out_q;

	logic [15:0]              cnt_base;
	logic signed [15:0]       raw;
	logic signed [ACC_W-1:0]  acc, p1, p2, base;
	logic signed [ACC_W-7:0]  shifted;
	logic signed [HIST_W-1:0] t;
	logic signed [HIST_W-1:0] t_bias;
	logic signed [HIST_W-17:0] q;
	logic signed [15:0]       smp;

	assign status.slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cnt_base = in_data.start_of_sample ? 16'd0 : block_cnt_q;

	// nibble in the top of a 16-bit word, arithmetic shift gives the floor
	assign raw  = $signed({nib_q[3:0], 12'h000}) >>> range_q;
	assign base = ACC_W'(raw) <<< 22;
	assign p1   = ACC_W'(h1_q) * ACC_W'($signed({1'b0, c1_q}));
	assign p2   = ACC_W'(h2_q) * ACC_W'($signed({1'b0, c2_q}));
	assign acc  = base + p1 - p2;
	assign shifted = acc[ACC_W-1:6];

	always_comb begin
		// clamp to the history range when the bits above it disagree with its sign
		if (shifted[ACC_W-7:HIST_W-1] != '0 && shifted[ACC_W-7:HIST_W-1] != '1)
			t = shifted[ACC_W-7] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
		else
			t = shifted[HIST_W-1:0];
	end

	// truncate toward zero: bias negatives before the shift
	assign t_bias = t + (t[HIST_W-1] ? HIST_W'(16'hFFFF) : HIST_W'(0));
	assign q      = t_bias[HIST_W-1:16];

	always_comb begin
		if (q > 24'sd32767)       smp = 16'sh7FFF;
		else if (q < -24'sd32768) smp = 16'sh8000;
		else                      smp = q[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_en_q  <= 1'b1;
			h1_q        <= '0;
			h2_q        <= '0;
			block_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) marks_en_q <= cfg_data;
			if (cmd.load) begin
				if (in_data.start_of_sample) begin
					h1_q <= '0;
					h2_q <= '0;
				end
				block_cnt_q <= (cnt_base < BLOCK_LIMIT) ? cnt_base + 16'd1 : cnt_base;
			end else if (cmd.step) begin
				h2_q <= h1_q;
				h1_q <= t;
			end
			if (cmd.step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nib_q        <= {in_data.data_high, in_data.data_low};
			range_q      <= in_data.shift_range;
			c1_q         <= coef_one(in_data.filter_select);
			c2_q         <= coef_two(in_data.filter_select);
			mark_start_q <= in_data.flag_loop_start & marks_en_q;
			mark_rep_q   <= in_data.flag_end & in_data.flag_repeat & marks_en_q;
			final_q      <= in_data.final_block;
			bidx_q       <= cnt_base;
		end else if (cmd.step) begin
			// advance to the next nibble
			nib_q <= {4'h0, nib_q[111:4]};
		end
		if (cmd.step) begin
			out_q.sample          <= smp;
			out_q.sample_index    <= cmd.idx;
			out_q.block_index     <= bidx_q;
			out_q.loop_start_here <= mark_start_q;
			out_q.loop_repeat     <= mark_rep_q;
			out_q.last            <= (cmd.idx == LAST_IDX);
			out_q.sample_done     <= (cmd.idx == LAST_IDX) && final_q;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.step)
		else $error("stalled transaction overwritten");

	a_step_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> out_valid_q)
		else $error("step did not present a transaction");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled transaction changed");

endmodule

FILE: hw/rtl/psx_adpcm_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// psx_adpcm_block_decoder_unit - 16-byte ADPCM block decoder
// Expands one block into 28 PCM samples through a two-tap predictor.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transaction carries one block (header, flags, 14 data bytes).
//   out_*  : 28 transactions per block, sample 0 first, last set on sample 27.
//   cfg_*  : writes the loop-mark enable bit; cfg_ready is always high.
// Start: the edge that accepts the block moves the sequencer to RUN; sample 0
//   is then stepped into the output register once that register is free.
// Throughput: one sample per cycle while out_ready keeps the output register
//   free, set by the predictor recurrence, which updates the history once per
//   sample. A block is accepted only in the idle state and holds the sequencer
//   until its last sample is stepped; in_ready is high only between blocks.
// Stall: a sample held in the output register while out_ready is low stops
//   the sequencer; nothing is dropped and the next sample follows once taken.
// Reset: history and block counter clear, loop marks enable, nothing pending.
//   start_of_sample in a block clears history and counter before that block.
// ----------------------------------------------------------------------------
module psx_adpcm_block_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pab_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pab_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import pab_pkg::*;

	pab_cmd_t    cmd;
	pab_status_t status;

	assign cfg_ready = 1'b1;

	pab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	pab_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: tb/tb_psx_adpcm_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_psx_adpcm_block_decoder_unit - self-checking bench for the block decoder
// Feeds 16-byte ADPCM blocks through the valid/ready input, predicts all 28
// samples of each block with a bit-exact software decoder, and checks every
// output transaction in order, with both sides idling at random in part of the run.
// ----------------------------------------------------------------------------
module tb_psx_adpcm_block_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pab_pkg::*;

	localparam longint HIST_TOP = 64'sd549755813887;
	localparam longint HIST_BOT = -HIST_TOP - 1;

	class sample_scoreboard;
		longint      hist_one;
		longint      hist_two;
		logic [15:0] block_count;
		logic        marks_on;
		out_item_t   pending_samples[$];
		int          errors;
		int          blocks_seen;
		int          samples_checked;

		function new();
			hist_one = 0;
			hist_two = 0;
			block_count = '0;
			marks_on = 1'b1;
			errors = 0;
			blocks_seen = 0;
			samples_checked = 0;
		endfunction

		function void set_marks(logic v);
			marks_on = v;
		endfunction

		// Expand the block into its 28 expected samples and advance the history.
		function void decode_block(in_item_t blk);
			logic [111:0] nib_bits;
			logic [3:0]   nib;
			longint       raw[28];
			longint       c1, c2, acc, t, s;
			out_item_t    e;
			nib_bits = {blk.data_high, blk.data_low};
			if (blk.start_of_sample) begin
				hist_one = 0;
				hist_two = 0;
				block_count = '0;
			end
			case (blk.filter_select)
				4'd1: begin c1 = 60;  c2 = 0;  end
				4'd2: begin c1 = 115; c2 = 52; end
				4'd3: begin c1 = 98;  c2 = 55; end
				4'd4: begin c1 = 122; c2 = 60; end
				default: begin c1 = 0; c2 = 0; end
			endcase
			for (int j = 0; j < 28; j++) begin
				nib = nib_bits[4*j +: 4];
				raw[j] = (longint'($signed(nib)) * 4096) >>> blk.shift_range;
			end
			for (int j = 0; j < 28; j++) begin
				if (c1 != 0) begin
					acc = raw[j] * 64 * 65536 + hist_one * c1 - hist_two * c2;
					t = acc >>> 6;
					if (t > HIST_TOP) t = HIST_TOP;
					if (t < HIST_BOT) t = HIST_BOT;
					hist_two = hist_one;
					hist_one = t;
					s = t / 65536;
				end else begin
					s = raw[j];
				end
				if (s > 32767) s = 32767;
				if (s < -32768) s = -32768;
				e.sample = 16'(s);
				e.sample_index = 5'(j);
				e.block_index = block_count;
				e.loop_start_here = blk.flag_loop_start & marks_on;
				e.loop_repeat = blk.flag_end & blk.flag_repeat & marks_on;
				e.last = (j == 27);
				e.sample_done = (j == 27) & blk.final_block;
				pending_samples = {pending_samples, e};
			end
			// pass-through blocks load the history from their last two samples
			if (c1 == 0) begin
				hist_two = raw[26] * 65536;
				hist_one = raw[27] * 65536;
			end
			if (block_count < BLOCK_LIMIT) block_count++;
			blocks_seen++;
		endfunction

		function void field_check(string name, logic [15:0] want, logic [15:0] seen);
			if (want !== seen)
				$display("%0t error: %s expected %0h got %0h", $time, name, want, seen);
		endfunction

		function void check_sample(out_item_t got);
			out_item_t want;
			if (pending_samples.size() == 0) begin
				errors++;
				$display("%0t error: sample with nothing expected, got %0h", $time, got);
				return;
			end
			want = pending_samples.pop_front();
			samples_checked++;
			if (got !== want) begin
				errors++;
				field_check("sample", want.sample, got.sample);
				field_check("sample_index", 16'(want.sample_index), 16'(got.sample_index));
				field_check("block_index", want.block_index, got.block_index);
				field_check("loop_start_here", 16'(want.loop_start_here),
					16'(got.loop_start_here));
				field_check("loop_repeat", 16'(want.loop_repeat), 16'(got.loop_repeat));
				field_check("last", 16'(want.last), 16'(got.last));
				field_check("sample_done", 16'(want.sample_done), 16'(got.sample_done));
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	sample_scoreboard sb = new();

	psx_adpcm_block_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Sample side: check each transaction, then roll the next stall.
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_sample(out_data);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [55:0] random_bytes();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[55:0];
	endfunction

	function automatic in_item_t block_of(logic sos, logic [3:0] rng, logic [3:0] flt,
		logic [2:0] flg, logic [55:0] lo, logic [55:0] hi, logic fin);
		in_item_t b;
		b.start_of_sample = sos;
		b.shift_range = rng;
		b.filter_select = flt;
		{b.flag_loop_start, b.flag_repeat, b.flag_end} = flg;
		b.data_low = lo;
		b.data_high = hi;
		b.final_block = fin;
		return b;
	endfunction

	function automatic in_item_t noise_block();
		return block_of(1'($urandom_range(1)), 4'($urandom_range(15)),
			4'($urandom_range(15)), 3'($urandom_range(7)), random_bytes(),
			random_bytes(), 1'($urandom_range(1)));
	endfunction

	// One block of a well-formed sample: start on the first, end flag on the last.
	function automatic in_item_t sample_block(logic first, logic fin);
		logic [3:0]  rng;
		logic [3:0]  flt;
		logic [3:0]  fill;
		logic [55:0] lo;
		logic [55:0] hi;
		rng = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
		flt = ($urandom_range(6) == 0) ? 4'($urandom_range(15, 5)) : 4'($urandom_range(4));
		if ($urandom_range(7) == 0) begin
			fill = 4'($urandom_range(15));
			lo = {14{fill}};
			hi = {14{fill}};
		end else begin
			lo = random_bytes();
			hi = random_bytes();
		end
		return block_of(first, rng, flt,
			{1'($urandom_range(3) == 0), fin & 1'($urandom_range(1)), fin},
			lo, hi, fin);
	endfunction

	task automatic send_block(input in_item_t blk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= blk;
		do @(posedge clk); while (!in_ready);
		sb.decode_block(blk);
	endtask

	task automatic write_marks(input logic v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_marks(v);
		cfg_valid <= 1'b0;
	endtask

	// Hold until every expected sample has been taken and the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(input int blocks);
		int goal;
		int len;
		goal = sb.blocks_seen + blocks;
		while (sb.blocks_seen < goal) begin
			if ($urandom_range(9) < 2) begin
				send_block(noise_block());
			end else begin
				len = $urandom_range(6, 1);
				for (int k = 0; k < len; k++) send_block(sample_block(k == 0, k == len - 1));
			end
		end
	endtask

	initial begin
		send_idle_pct = 29;
		recv_idle_pct = 88;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks, loop marks at their reset value
		send_block(block_of(1'b1, 4'd0, 4'd0, 3'b100, 56'h0F870F870F870F,
			56'hF078F078F078F0, 1'b0));
		send_block(block_of(1'b0, 4'd0, 4'd1, 3'b000, {14{4'h7}}, {14{4'h7}}, 1'b0));
		repeat (3) send_block(block_of(1'b0, 4'd0, 4'd2, 3'b000, {14{4'h7}}, {14{4'h7}}, 1'b0));
		repeat (3) send_block(block_of(1'b0, 4'd0, 4'd2, 3'b000, {14{4'h8}}, {14{4'h8}}, 1'b0));
		send_block(block_of(1'b0, 4'd12, 4'd3, 3'b000, random_bytes(), random_bytes(), 1'b0));
		send_block(block_of(1'b0, 4'd15, 4'd4, 3'b000, {14{4'hF}}, {14{4'hF}}, 1'b0));
		send_block(block_of(1'b0, 4'd4, 4'd4, 3'b100, random_bytes(), random_bytes(), 1'b0));
		send_block(block_of(1'b0, 4'd2, 4'd5, 3'b000, random_bytes(), random_bytes(), 1'b0));
		send_block(block_of(1'b0, 4'd9, 4'd15, 3'b011, random_bytes(), random_bytes(), 1'b1));
		send_block(block_of(1'b1, 4'd0, 4'd0, 3'b001, '0, '0, 1'b0));
		send_block(block_of(1'b0, 4'd3, 4'd1, 3'b010, '1, '1, 1'b0));
		send_block(block_of(1'b0, 4'd0, 4'd4, 3'b111, {14{4'h8}}, {14{4'h8}}, 1'b0));
		send_block(block_of(1'b0, 4'd13, 4'd2, 3'b011, random_bytes(), random_bytes(), 1'b1));
		drain();

		write_marks(1'b0);
		run_random(45);
		drain();

		send_idle_pct = 88;
		recv_idle_pct = 29;
		write_marks(1'b1);
		run_random(45);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_marks(1'b0);
		run_random(20);
		drain();
		write_marks(1'b1);
		run_random(20);
		drain();

		// allow any stray sample to show up before closing
		repeat (32) @(posedge clk);
		$display("Decoded %0d blocks, %0d samples compared against the predictor.",
			sb.blocks_seen, sb.samples_checked);
		$display("Filters 0-15, shift ranges 0-15, loop marks on and off, %0d bad samples.",
			sb.errors);
		if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/pab_pkg.sv
hw/rtl/pab_ctrl.sv
hw/rtl/pab_datapath.sv
hw/rtl/psx_adpcm_block_decoder_unit.sv
tb/tb_psx_adpcm_block_decoder_unit.sv
